// File: design/adc_otb_pkg.sv
// ----------------------------------------------------------------------------
// adc_otb_pkg
// Shared types and constants for the oversampling triple-buffer capture block.
// ----------------------------------------------------------------------------
package adc_otb_pkg;

    // Field widths of the stream items and registers
    localparam int CMD_W      = 2;
    localparam int CODE_W     = 20;
    localparam int IDX_W      = 12;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int BUF_W      = 2;
    localparam int GRACE_W    = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

    // Front-to-back queue geometry
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERSAMPLE = 2'd0,
        CFG_OFFSET     = 2'd1,
        CFG_NO_SKIP    = 2'd2
    } t_cfg_idx;

    // Classified request as it travels from front to back
    typedef struct packed {
        logic             stored;
        logic [SUM_W-1:0] sum_value;
        logic [BUF_W-1:0] store_buffer;
        logic [IDX_W-1:0] store_position;
        logic             buffer_ready;
        logic [BUF_W-1:0] drain_index;
        logic             overrun;
        logic             halted;
        logic             released;
        logic             rd_valid;   // memory read of an in-range word
    } t_result;

endpackage

// File: design/adc_otb_front.sv
// ----------------------------------------------------------------------------
// adc_otb_front
// Configuration registers, accumulator and buffer bookkeeping; turns each
// request into a result record plus a capture memory address.
// ----------------------------------------------------------------------------
module adc_otb_front #(
    parameter int WORDS          = 4096,
    parameter int BUFFERS        = 3,
    parameter int GRACE_RELEASES = 2,
    parameter int AW             = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adc_otb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adc_otb_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                                i_fire,
    input  logic [adc_otb_pkg::CMD_W-1:0]       i_cmd,
    input  logic [adc_otb_pkg::CODE_W-1:0]      i_raw_code,
    input  logic [adc_otb_pkg::IDX_W-1:0]       i_word_index,
    output adc_otb_pkg::t_result                o_rec,
    output logic [AW-1:0]                       o_addr
);

    localparam int PW  = $clog2(WORDS);
    localparam int SW  = adc_otb_pkg::SUM_W;
    localparam int CW  = adc_otb_pkg::CNT_W;
    localparam int BW  = adc_otb_pkg::BUF_W;
    localparam int GW  = adc_otb_pkg::GRACE_W;
    localparam int XW  = SW - adc_otb_pkg::CODE_W;

    // Configuration registers
    logic [CW-1:0]                  r_os_count;
    logic [adc_otb_pkg::CFG_W-1:0]  r_offset;
    logic                           r_no_skip;

    // Capture state
    logic [SW-1:0] r_acc,      n_acc;
    logic [CW-1:0] r_taken,    n_taken;
    logic [BW-1:0] r_fill_buf, n_fill_buf;
    logic [PW-1:0] r_pos,      n_pos;
    logic [BW-1:0] r_drain,    n_drain;
    logic          r_ready,    n_ready;
    logic [GW-1:0] r_grace,    n_grace;
    logic          r_halted,   n_halted;

    logic [SW-1:0] sample_sum;
    logic [CW-1:0] cnt_inc;
    logic [BW-1:0] fill_inc;
    logic [BW-1:0] drain_inc;
    logic          pos_last;
    logic          idx_in_range;
    logic [31:0]   pos_ext;
    logic [AW-1:0] st_addr;
    logic [AW-1:0] rd_addr;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os_count <= CW'(1);
            r_offset   <= '0;
            r_no_skip  <= 1'b1;
        end else if (i_cfg_we) begin
            case (adc_otb_pkg::t_cfg_idx'(i_cfg_index))
                adc_otb_pkg::CFG_OVERSAMPLE: r_os_count <= i_cfg_data[CW-1:0];
                adc_otb_pkg::CFG_OFFSET:     r_offset   <= i_cfg_data;
                adc_otb_pkg::CFG_NO_SKIP:    r_no_skip  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Datapath terms shared by the command decode
    assign sample_sum = r_acc + {{XW{i_raw_code[adc_otb_pkg::CODE_W-1]}}, i_raw_code}
                              + {{XW{r_offset[adc_otb_pkg::CFG_W-1]}}, r_offset};
    assign cnt_inc    = r_taken + CW'(1);
    assign fill_inc   = (32'(r_fill_buf) == 32'(BUFFERS - 1)) ? '0 : r_fill_buf + BW'(1);
    assign drain_inc  = (32'(r_drain) == 32'(BUFFERS - 1)) ? '0 : r_drain + BW'(1);
    assign pos_last   = (32'(r_pos) == 32'(WORDS - 1));
    assign idx_in_range = (32'(i_word_index) < 32'(WORDS));
    assign pos_ext    = 32'(r_pos);
    assign st_addr    = AW'(r_fill_buf) * AW'(WORDS) + AW'(r_pos);
    assign rd_addr    = AW'(r_drain) * AW'(WORDS) + AW'(i_word_index);

    // Command decode and next state
    always_comb begin
        n_acc      = r_acc;
        n_taken    = r_taken;
        n_fill_buf = r_fill_buf;
        n_pos      = r_pos;
        n_drain    = r_drain;
        n_ready    = r_ready;
        n_grace    = r_grace;
        n_halted   = r_halted;
        o_rec      = '0;
        o_addr     = '0;

        case (adc_otb_pkg::t_cmd'(i_cmd))
            adc_otb_pkg::CMD_SAMPLE: begin
                if (!r_halted) begin
                    n_acc   = sample_sum;
                    n_taken = cnt_inc;
                    if (cnt_inc >= r_os_count) begin
                        o_rec.stored         = 1'b1;
                        o_rec.sum_value      = sample_sum;
                        o_rec.store_buffer   = r_fill_buf;
                        o_rec.store_position = pos_ext[adc_otb_pkg::IDX_W-1:0];
                        o_addr               = st_addr;
                        n_pos                = r_pos + PW'(1);
                        // Buffer full: rotate, flag ready, check overrun
                        if (pos_last) begin
                            n_pos      = '0;
                            n_fill_buf = fill_inc;
                            n_ready    = 1'b1;
                            if (r_no_skip && fill_inc == r_drain) begin
                                if (r_grace != '0) begin
                                    n_ready        = 1'b0;
                                    n_drain        = drain_inc;
                                    o_rec.released = 1'b1;
                                    n_grace        = r_grace - GW'(1);
                                end else begin
                                    o_rec.overrun = 1'b1;
                                    n_halted      = 1'b1;
                                end
                            end
                        end
                        n_acc   = '0;
                        n_taken = '0;
                    end
                end
            end
            adc_otb_pkg::CMD_READ: begin
                o_rec.rd_valid = idx_in_range;
                o_addr         = rd_addr;
            end
            adc_otb_pkg::CMD_RELEASE: begin
                if (r_ready) begin
                    n_ready        = 1'b0;
                    n_drain        = drain_inc;
                    o_rec.released = 1'b1;
                end
            end
            default: ;
        endcase

        o_rec.buffer_ready = n_ready;
        o_rec.drain_index  = n_drain;
        o_rec.halted       = n_halted;
    end

    // State update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_taken    <= '0;
            r_fill_buf <= '0;
            r_pos      <= '0;
            r_drain    <= '0;
            r_ready    <= 1'b0;
            r_grace    <= GW'(GRACE_RELEASES);
            r_halted   <= 1'b0;
        end else if (i_fire) begin
            r_acc      <= n_acc;
            r_taken    <= n_taken;
            r_fill_buf <= n_fill_buf;
            r_pos      <= n_pos;
            r_drain    <= n_drain;
            r_ready    <= n_ready;
            r_grace    <= n_grace;
            r_halted   <= n_halted;
        end
    end

endmodule

// File: design/adc_otb_queue.sv
// ----------------------------------------------------------------------------
// adc_otb_queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module adc_otb_queue #(
    parameter int AW = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  adc_otb_pkg::t_result  i_rec,
    input  logic [AW-1:0]         i_addr,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_pop,
    output adc_otb_pkg::t_result  o_rec,
    output logic [AW-1:0]         o_addr
);

    localparam int DEPTH = adc_otb_pkg::QDEPTH;
    localparam int PTW   = adc_otb_pkg::QPTR_W;
    localparam int CTW   = adc_otb_pkg::QCNT_W;

    adc_otb_pkg::t_result r_rec  [DEPTH];
    logic [AW-1:0]        r_addr [DEPTH];
    logic [PTW-1:0]       r_wr_ptr;
    logic [PTW-1:0]       r_rd_ptr;
    logic [CTW-1:0]       r_count;

    assign o_full  = (r_count == CTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_rec[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rec[r_wr_ptr]  <= i_rec;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CTW'(1);
            end
        end
    end

endmodule

// File: design/adc_otb_back.sv
// ----------------------------------------------------------------------------
// adc_otb_back
// Capture memory access and output register: writes stored sums, reads
// drain-buffer words and presents one result per request.
// ----------------------------------------------------------------------------
module adc_otb_back #(
    parameter int AW    = 14,
    parameter int DEPTH = 12288
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_pop,
    input  adc_otb_pkg::t_result                  i_rec,
    input  logic [AW-1:0]                         i_addr,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [adc_otb_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    localparam int SW = adc_otb_pkg::SUM_W;

    logic [SW-1:0]        r_mem [DEPTH];
    logic [SW-1:0]        r_rd_data;
    adc_otb_pkg::t_result r_out;
    logic                 r_out_valid;
    logic [SW-1:0]        read_word;

    // Take the next request when the output register is free or draining
    assign o_pop = i_valid && (!r_out_valid || i_m_axis_tready);

    // Capture memory, one port: write of a stored sum or read for the host
    always_ff @(posedge i_clk) begin
        if (o_pop && i_rec.stored) begin
            r_mem[i_addr] <= i_rec.sum_value;
        end
        if (o_pop && i_rec.rd_valid) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign read_word = r_out.rd_valid ? r_rd_data : '0;

    // Pack result fields, highest first
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000,
                              r_out.released,
                              read_word,
                              r_out.halted,
                              r_out.overrun,
                              r_out.drain_index,
                              r_out.buffer_ready,
                              r_out.store_position,
                              r_out.store_buffer,
                              r_out.sum_value,
                              r_out.stored};

endmodule

// File: design/adc_oversample_triple_buffer_capture_top.sv
// ----------------------------------------------------------------------------
// adc_oversample_triple_buffer_capture_top
// Oversampling accumulator feeding three rotating capture buffers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries requests: tuser holds the command (sample, read
//   word, release drain buffer); tdata holds the converter code and the read
//   word index. Every request yields exactly one result on the master stream.
//   Configuration (oversample count, offset, no-skip) is written through a
//   plain write port while no request is in flight.
//   Throughput: one request per cycle while the queue has room; the
//   accumulator and buffer pointers update on acceptance in the front part,
//   the capture memory is one port accessed once per request in the back part.
//   Result path: an accepted request is written into the queue, then its
//   memory access and result are registered into the output register once
//   that register is free or draining.
//   Reset (synchronous, active low): accumulator, pointers and flags clear,
//   grace count reloads, registers take their defaults; capture memory is
//   not cleared and only written words should be read.
//   Receiver stall: the output register holds its result, the two-entry
//   queue absorbs further requests, then tready drops until the sink drains.
// ----------------------------------------------------------------------------
module adc_oversample_triple_buffer_capture_top #(
    parameter int WORDS_PER_BUFFER = 4096,
    parameter int BUFFER_COUNT     = 3,
    parameter int GRACE_RELEASES   = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [adc_otb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adc_otb_pkg::CFG_W-1:0]        i_cfg_data,
    // request stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [19:0] raw_code, [31:20] word_index
    input  logic [adc_otb_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] command
    input  logic [adc_otb_pkg::CMD_W-1:0]        i_s_axis_tuser,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [0] stored, [32:1] sum_value, [34:33] store_buffer, [46:35] store_position,
    // [47] buffer_ready, [49:48] drain_index, [50] overrun, [51] halted,
    // [83:52] read_word, [84] released, [87:85] zero
    output logic [adc_otb_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam int DEPTH = BUFFER_COUNT * WORDS_PER_BUFFER;
    localparam int AW    = $clog2(DEPTH);

    logic                 fire;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    adc_otb_pkg::t_result front_rec;
    logic [AW-1:0]        front_addr;
    adc_otb_pkg::t_result q_rec;
    logic [AW-1:0]        q_addr;

    assign o_s_axis_tready = !q_full;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    adc_otb_front #(
        .WORDS          (WORDS_PER_BUFFER),
        .BUFFERS        (BUFFER_COUNT),
        .GRACE_RELEASES (GRACE_RELEASES),
        .AW             (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_cmd        (i_s_axis_tuser),
        .i_raw_code   (i_s_axis_tdata[19:0]),
        .i_word_index (i_s_axis_tdata[31:20]),
        .o_rec        (front_rec),
        .o_addr       (front_addr)
    );

    adc_otb_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_rec   (front_rec),
        .i_addr  (front_addr),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rec   (q_rec),
        .o_addr  (q_addr)
    );

    adc_otb_back #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_pop           (q_pop),
        .i_rec           (q_rec),
        .i_addr          (q_addr),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // An overrun result always reports capture halted
    a_overrun_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[50] |-> o_m_axis_tdata[51])
        else $error("overrun reported without halt");

    // A released buffer leaves no buffer ready
    a_release_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[84] |-> !o_m_axis_tdata[47])
        else $error("buffer still ready after release");

    // Request side only backs up behind a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("request side stalled without output stall");

endmodule

// File: dv/tb_adc_oversample_triple_buffer_capture_top.sv
// ----------------------------------------------------------------------------
// tb_adc_oversample_triple_buffer_capture_top
// Self-checking bench for the oversampling triple-buffer capture block: a
// scoreboard tracks accumulator, buffer pointers, flags and capture memory
// per accepted request and checks every result field. Stimulus runs a
// directed part, then mixed random traffic under several register settings
// and idling patterns.
// ----------------------------------------------------------------------------
module tb_adc_oversample_triple_buffer_capture_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W      = adc_otb_pkg::CMD_W;
    localparam int CODE_W     = adc_otb_pkg::CODE_W;
    localparam int IDX_W      = adc_otb_pkg::IDX_W;
    localparam int SUM_W      = adc_otb_pkg::SUM_W;
    localparam int CNT_W      = adc_otb_pkg::CNT_W;
    localparam int CFG_W      = adc_otb_pkg::CFG_W;
    localparam int CFG_IDX_W  = adc_otb_pkg::CFG_IDX_W;
    localparam int BUF_W      = adc_otb_pkg::BUF_W;
    localparam int IN_DATA_W  = adc_otb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = adc_otb_pkg::OUT_DATA_W;

    localparam int WORDS   = 4096;
    localparam int BUFFERS = 3;
    localparam int GRACE   = 2;

    // Command code the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Request fields as they travel on the slave stream
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CODE_W-1:0] raw;
        logic [IDX_W-1:0]  idx;
    } t_capture_request;

    // Result layout of the master stream tdata, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic              released;
        logic [SUM_W-1:0]  read_word;
        logic              halted;
        logic              overrun;
        logic [BUF_W-1:0]  drain_index;
        logic              buffer_ready;
        logic [IDX_W-1:0]  store_position;
        logic [BUF_W-1:0]  store_buffer;
        logic [SUM_W-1:0]  sum_value;
        logic              stored;
    } t_capture_report;

    // ------------------------------------------------------------------------
    // Scoreboard: predicted block state and the results still to arrive
    // ------------------------------------------------------------------------
    class t_capture_scoreboard;
        bit [CNT_W-1:0]  oversample_count;
        bit [CODE_W-1:0] offset_correction;
        bit              no_skip;

        bit [SUM_W-1:0]  accum;
        bit [CNT_W-1:0]  taken;
        bit [SUM_W-1:0]  mem [BUFFERS*WORDS];
        int              written_words [BUFFERS];
        int              fill_buf;
        int              fill_pos;
        int              drain_buf;
        bit              ready;
        int              grace;
        bit              halted;

        t_capture_report expected_reports [$];
        int unsigned     errors;

        function void reset_state();
            oversample_count  = 1;
            offset_correction = '0;
            no_skip           = 1'b1;
            accum             = '0;
            taken             = '0;
            fill_buf          = 0;
            fill_pos          = 0;
            drain_buf         = 0;
            ready             = 1'b0;
            grace             = GRACE;
            halted            = 1'b0;
            foreach (written_words[b]) written_words[b] = 0;
        endfunction

        function void write_config(adc_otb_pkg::t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                adc_otb_pkg::CFG_OVERSAMPLE: oversample_count  = val[CNT_W-1:0];
                adc_otb_pkg::CFG_OFFSET:     offset_correction = val[CODE_W-1:0];
                adc_otb_pkg::CFG_NO_SKIP:    no_skip           = val[0];
                default: ;
            endcase
        endfunction

        function bit [SUM_W-1:0] widen_code(bit [CODE_W-1:0] c);
            return {{(SUM_W-CODE_W){c[CODE_W-1]}}, c};
        endfunction

        // frees the drain buffer when a full one is waiting
        function bit free_drain();
            if (!ready) return 1'b0;
            ready     = 1'b0;
            drain_buf = (drain_buf + 1) % BUFFERS;
            return 1'b1;
        endfunction

        function void note_request(t_capture_request r);
            t_capture_report e;
            e = '0;
            case (r.cmd)
                adc_otb_pkg::CMD_SAMPLE: begin
                    if (!halted) begin
                        accum = accum + widen_code(r.raw) + widen_code(offset_correction);
                        taken = taken + CNT_W'(1);
                        if (taken >= oversample_count) begin
                            e.stored         = 1'b1;
                            e.sum_value      = accum;
                            e.store_buffer   = fill_buf[BUF_W-1:0];
                            e.store_position = fill_pos[IDX_W-1:0];
                            mem[fill_buf*WORDS + fill_pos] = accum;
                            if (written_words[fill_buf] < fill_pos + 1)
                                written_words[fill_buf] = fill_pos + 1;
                            fill_pos++;
                            // buffer full: rotate, then look for an overrun
                            if (fill_pos >= WORDS) begin
                                fill_buf = (fill_buf + 1) % BUFFERS;
                                fill_pos = 0;
                                ready    = 1'b1;
                                if (no_skip && fill_buf == drain_buf) begin
                                    if (grace > 0) begin
                                        e.released = free_drain();
                                        grace--;
                                    end else begin
                                        e.overrun = 1'b1;
                                        halted    = 1'b1;
                                    end
                                end
                            end
                            accum = '0;
                            taken = '0;
                        end
                    end
                end
                adc_otb_pkg::CMD_READ: begin
                    if (int'(r.idx) < WORDS)
                        e.read_word = mem[drain_buf*WORDS + int'(r.idx)];
                end
                adc_otb_pkg::CMD_RELEASE: e.released = free_drain();
                default: ;
            endcase
            e.buffer_ready = ready;
            e.drain_index  = drain_buf[BUF_W-1:0];
            e.halted       = halted;
            expected_reports.push_back(e);
        endfunction

        function void flag_error(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void compare_field(string name, logic [SUM_W-1:0] exp_v,
                                    logic [SUM_W-1:0] act_v);
            if (act_v !== exp_v)
                flag_error($sformatf("%s mismatch: expected %h actual %h", name, exp_v, act_v));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_capture_report act;
            t_capture_report exp_r;
            act = data;
            if (expected_reports.size() == 0) begin
                flag_error($sformatf("result with nothing pending: expected none actual %h",
                                     data));
                return;
            end
            exp_r = expected_reports.pop_front();
            compare_field("stored",         SUM_W'(exp_r.stored),       SUM_W'(act.stored));
            compare_field("sum_value",      exp_r.sum_value,            act.sum_value);
            compare_field("store_buffer",   SUM_W'(exp_r.store_buffer), SUM_W'(act.store_buffer));
            compare_field("store_position", SUM_W'(exp_r.store_position),
                          SUM_W'(act.store_position));
            compare_field("buffer_ready",   SUM_W'(exp_r.buffer_ready), SUM_W'(act.buffer_ready));
            compare_field("drain_index",    SUM_W'(exp_r.drain_index),  SUM_W'(act.drain_index));
            compare_field("overrun",        SUM_W'(exp_r.overrun),      SUM_W'(act.overrun));
            compare_field("halted",         SUM_W'(exp_r.halted),       SUM_W'(act.halted));
            compare_field("read_word",      exp_r.read_word,            act.read_word);
            compare_field("released",       SUM_W'(exp_r.released),     SUM_W'(act.released));
            compare_field("pad",            SUM_W'(exp_r.pad),          SUM_W'(act.pad));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench signals
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [CMD_W-1:0]      i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    t_capture_scoreboard sb = new;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    // long hold-off: the stimulus posts a length, the sink counts it down
    int hold_cycles   = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #4 i_clk = ~i_clk;

    adc_oversample_triple_buffer_capture_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Result sink: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_cycles;
        end
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb_adc_oversample_triple_buffer_capture_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // one request; returns at the falling edge after acceptance
    task automatic send_request(input t_capture_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = IN_DATA_W'($urandom);
            i_s_axis_tuser  = CMD_W'($urandom);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {r.idx, r.raw};
        i_s_axis_tuser  = r.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input adc_otb_pkg::t_cfg_idx idx,
                                  input logic [CFG_W-1:0] val);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_config(idx, val);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] raw,
                               input logic [IDX_W-1:0] idx);
        t_capture_request r;
        r.cmd = cmd;
        r.raw = raw;
        r.idx = idx;
        send_request(r);
    endtask

    // converter code, leaning on the range ends now and then
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(15))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return 20'h00000;
            3: return 20'hFFFFF;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    // random request; reads only touch words already written in the drain buffer
    function automatic t_capture_request pick_request(int sample_pct, int read_pct,
                                                      int release_pct);
        t_capture_request r;
        int roll;
        int avail;
        roll  = $urandom_range(99);
        avail = sb.written_words[sb.drain_buf];
        r.raw = pick_code();
        r.idx = IDX_W'($urandom);
        if (roll < sample_pct) begin
            r.cmd = adc_otb_pkg::CMD_SAMPLE;
        end else if (roll < sample_pct + read_pct) begin
            if (avail == 0) begin
                r.cmd = adc_otb_pkg::CMD_SAMPLE;
            end else begin
                r.cmd = adc_otb_pkg::CMD_READ;
                case ($urandom_range(7))
                    0: r.idx = '0;
                    1: r.idx = IDX_W'(avail - 1);
                    default: r.idx = IDX_W'($urandom_range(avail - 1));
                endcase
            end
        end else if (roll < sample_pct + read_pct + release_pct) begin
            r.cmd = adc_otb_pkg::CMD_RELEASE;
        end else begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        sb.reset_state();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: code extremes with default registers
        set_idling(0);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h7FFFF, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h80000, 12'hFFF);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h00000, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'hFFFFF, 12'hFFF);
        send_fields(adc_otb_pkg::CMD_READ,   20'h00000, 12'd0);
        send_fields(adc_otb_pkg::CMD_READ,   20'hFFFFF, 12'd3);
        send_fields(adc_otb_pkg::CMD_RELEASE, 20'hFFFFF, 12'hFFF);   // nothing ready yet
        send_fields(CMD_UNUSED, 20'hFFFFF, 12'hFFF);
        send_fields(adc_otb_pkg::CMD_READ,   20'hFFFFF, 12'd1);
        // offset extremes, pairs of samples
        write_register(adc_otb_pkg::CFG_OFFSET, 20'h7FFFF);
        write_register(adc_otb_pkg::CFG_OVERSAMPLE, 20'd2);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h7FFFF, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h7FFFF, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h80000, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h80000, 12'h000);
        // count of zero stores every sample
        write_register(adc_otb_pkg::CFG_OFFSET, 20'h80000);
        write_register(adc_otb_pkg::CFG_OVERSAMPLE, 20'd0);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h80000, 12'h000);
        send_fields(adc_otb_pkg::CMD_SAMPLE, 20'h7FFFF, 12'h000);
        send_fields(adc_otb_pkg::CMD_READ,   20'h00000, 12'd5);
        send_fields(adc_otb_pkg::CMD_READ,   20'h00000, 12'd6);
        write_register(adc_otb_pkg::CFG_OVERSAMPLE, 20'd3);
        write_register(adc_otb_pkg::CFG_NO_SKIP, 20'd0);
        repeat (4) send_fields(adc_otb_pkg::CMD_SAMPLE, pick_code(), IDX_W'($urandom));
        send_fields(CMD_UNUSED, 20'h00000, 12'h000);

        // random mixed traffic under four register settings
        for (int mode = 0; mode < 4; mode++) begin
            set_idling(mode);
            write_register(adc_otb_pkg::CFG_OVERSAMPLE, CFG_W'($urandom_range(1, 4)));
            write_register(adc_otb_pkg::CFG_OFFSET, (mode == 1) ? 20'h7FFFF :
                                                    (mode == 2) ? 20'h80000 : pick_code());
            write_register(adc_otb_pkg::CFG_NO_SKIP, CFG_W'(mode % 2));
            for (int i = 0; i < 300; i++) begin
                if (mode == 0 && i == 100) begin
                    // back-pressure the result stream
                    hold_cycles = 300;
                    hold_seq++;
                end
                if (mode == 3 && i == 160) wait_drained();
                send_request(pick_request(60, 20, 12));
            end
        end

        // closing mix of samples, reads, releases and unused commands
        set_idling(3);
        for (int i = 0; i < 60; i++)
            send_request(pick_request(50, 30, 15));

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_adc_oversample_triple_buffer_capture_top: clean");
        else
            $display("tb_adc_oversample_triple_buffer_capture_top: errors");
        $finish;
    end

endmodule

// File: sim.f
design/adc_otb_pkg.sv
design/adc_otb_front.sv
design/adc_otb_queue.sv
design/adc_otb_back.sv
design/adc_oversample_triple_buffer_capture_top.sv
dv/tb_adc_oversample_triple_buffer_capture_top.sv
